// ===== rtl/cdtd_pkg.sv =====
// shared types and constants of the color difference threshold and dilate unit
package cdtd_pkg;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   localparam int CHAN_W     = 8;
   localparam int COORD_W    = 11;
   localparam int DIM_W      = 12;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 12;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [CHAN_W-1:0] RESET_THRESHOLD = 8'd128;
   localparam logic [DIM_W-1:0]  RESET_WIDTH     = 12'd640;
   localparam logic [DIM_W-1:0]  RESET_HEIGHT    = 12'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLOR_SELECT = 4'd0,
      CSR_THRESHOLD    = 4'd1,
      CSR_IMAGE_WIDTH  = 4'd2,
      CSR_IMAGE_HEIGHT = 4'd3
   } csr_index_type;

   typedef enum logic {
      REQ_PIXEL = 1'b0,
      REQ_FLUSH = 1'b1
   } req_kind_type;

   // one line store entry: bit two rows back, bit one row back and its valid flag
   typedef struct packed {
      logic mid_valid;
      logic mid;
      logic up;
   } line_word_type;

   localparam int LINE_WORD_W = $bits(line_word_type);

endpackage

// ===== rtl/cdtd_ram.sv =====
// generic single-write, single-read ram with registered read data
module cdtd_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents when the same entry is written in that cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/color_difference_threshold_dilate_unit.sv =====
// top level: color difference threshold followed by 3x3 cross dilation
//
//   channel  dir  handshake                content
//   req      in   req_tvalid/req_tready    tdata blue, red; tuser pixel or flush
//   rsp      out  rsp_tvalid/rsp_tready    tdata bright, col, row; tlast frame end
//   csr      in   csr_valid/csr_ready      register index and write data
//
// one item is taken per cycle unless rsp stalls; its line store entry is read on accept and
// written back from the read stage, with the previous write forwarded when both touch the same column.
// a result comes out for the item W+1 transfers back, through the read stage and the output register.
// after reset a clearing pass zeroes every line store entry; req is held off.
// a stalled rsp holds the output register and then the read stage, which stops req.
module color_difference_threshold_dilate_unit
   import cdtd_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // blue [7:0], red [15:8]
   input  logic                  req_tuser,   // req_type [0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // bright [0], col [11:1], row [22:12], zero pad
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int XWW = (WW > DIM_W) ? WW : DIM_W;
   localparam int XHW = (HW > DIM_W) ? HW : DIM_W;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   // configuration
   logic              color_select_ff;
   logic [CHAN_W-1:0] threshold_ff;
   logic [DIM_W-1:0]  width_ff;
   logic [DIM_W-1:0]  height_ff;

   state_type state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;

   logic [WW-1:0]  w;
   logic [HW-1:0]  h;
   logic [XWW-1:0] width_ext;
   logic [XHW-1:0] height_ext;

   logic accept, stall, s1_go;

   // input side
   logic [CHAN_W-1:0] blue, red, hi, lo, diff;
   logic              pix_bit, pix_valid;
   logic [CW-1:0]     in_col_ff, in_col_in, c_sel;

   // read stage
   logic          s1_valid_ff, s1_valid_in;
   logic [CW-1:0] s1_col_ff;
   logic          s1_bit_ff, s1_pix_ff, s1_fwd_ff;
   line_word_type s1_fwd_data_ff;

   // line store ports
   logic          ram_wr_en, ram_rd_en;
   logic [CW-1:0] ram_wr_addr;
   line_word_type ram_wr_word, ram_rd_word, cur_word;
   logic [LINE_WORD_W-1:0] ram_rd_data;

   // window and result side
   logic [2:0]    window_ff, window_in;
   logic [1:0]    vwin_ff, vwin_in;
   logic          above_ff, below_ff;
   logic [CW-1:0] out_col_ff, out_col_in, col_eff;
   logic [RW-1:0] out_row_ff, out_row_in, row_eff;
   logic          has_result, dil, last_col, last_row;
   logic [CW+COORD_W-1:0] col_wide;
   logic [RW+COORD_W-1:0] row_wide;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_bright_ff, rsp_last_ff;
   logic [COORD_W-1:0] rsp_col_ff, rsp_row_ff;

   // frame size, 0 acts as 1 and oversize acts as the maximum
   assign width_ext  = XWW'(width_ff);
   assign height_ext = XHW'(height_ff);
   assign w = (width_ext == '0) ? WW'(1) :
              (width_ext > XWW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_ext);
   assign h = (height_ext == '0) ? HW'(1) :
              (height_ext > XHW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(height_ext);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_select_ff <= 1'b0;
         threshold_ff    <= RESET_THRESHOLD;
         width_ff        <= RESET_WIDTH;
         height_ff       <= RESET_HEIGHT;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COLOR_SELECT: color_select_ff <= csr_data[0];
            CSR_THRESHOLD:    threshold_ff    <= csr_data[CHAN_W-1:0];
            CSR_IMAGE_WIDTH:  width_ff        <= csr_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff       <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // clearing pass over the line store after reset
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(MAX_WIDTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: ;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // handshake
   assign stall      = rsp_valid_ff && !rsp_tready;
   assign s1_go      = s1_valid_ff && !stall;
   assign req_tready = (state_ff == ST_RUN) && (!s1_valid_ff || !stall);
   assign accept     = req_tvalid && req_tready;

   // threshold of the saturating difference
   assign blue      = req_tdata[CHAN_W-1:0];
   assign red       = req_tdata[2*CHAN_W-1:CHAN_W];
   assign hi        = color_select_ff ? blue : red;
   assign lo        = color_select_ff ? red : blue;
   assign diff      = (hi > lo) ? hi - lo : '0;
   assign pix_valid = (req_tuser == REQ_PIXEL);
   assign pix_bit   = pix_valid && (diff > threshold_ff);

   // write column, wraps at the frame width
   assign c_sel     = (WW'(in_col_ff) >= w) ? '0 : in_col_ff;
   assign in_col_in = ((WW'(c_sel) + WW'(1)) >= w) ? '0 : c_sel + CW'(1);

   assign s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            in_col_ff <= in_col_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff      <= c_sel;
         s1_bit_ff      <= pix_bit;
         s1_pix_ff      <= pix_valid;
         // the write in this cycle is not yet seen by the ram read
         s1_fwd_ff      <= s1_go && (s1_col_ff == c_sel);
         s1_fwd_data_ff <= ram_wr_word;
      end
   end

   // line store read-modify-write
   assign cur_word    = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_word;
   assign ram_rd_en   = accept;
   assign ram_rd_word = line_word_type'(ram_rd_data);

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_word = '0;
      end else begin
         ram_wr_en             = s1_go;
         ram_wr_addr           = s1_col_ff;
         ram_wr_word.mid_valid = s1_pix_ff;
         ram_wr_word.mid       = s1_bit_ff;
         ram_wr_word.up        = cur_word.mid;
      end
   end

   cdtd_ram #(
      .WIDTH (LINE_WORD_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_word),
      .rd_en   (ram_rd_en),
      .rd_addr (c_sel),
      .rd_data (ram_rd_data)
   );

   // window over the row above the newest slot
   assign window_in  = {window_ff[1:0], cur_word.mid};
   assign vwin_in    = {vwin_ff[0], cur_word.mid_valid};
   assign has_result = vwin_in[1];

   assign col_eff  = (WW'(out_col_ff) >= w) ? '0 : out_col_ff;
   assign row_eff  = (HW'(out_row_ff) >= h) ? '0 : out_row_ff;
   assign last_col = (WW'(col_eff) + WW'(1)) == w;
   assign last_row = (HW'(row_eff) + HW'(1)) == h;

   // cross element, neighbors outside the frame are clear
   assign dil = window_in[1]
              | ((row_eff != '0) & above_ff)
              | (!last_row & below_ff)
              | ((col_eff != '0) & window_in[2])
              | (!last_col & window_in[0]);

   always_comb begin
      out_col_in = col_eff + CW'(1);
      out_row_in = row_eff;
      if (last_col) begin
         out_col_in = '0;
         out_row_in = last_row ? '0 : row_eff + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '0;
         vwin_ff    <= '0;
         above_ff   <= 1'b0;
         below_ff   <= 1'b0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (s1_go) begin
         window_ff <= window_in;
         vwin_ff   <= vwin_in;
         above_ff  <= cur_word.up;
         below_ff  <= s1_bit_ff;
         if (has_result) begin
            out_col_ff <= out_col_in;
            out_row_ff <= out_row_in;
         end
      end
   end

   // output register
   assign col_wide     = (CW + COORD_W)'(col_eff);
   assign row_wide     = (RW + COORD_W)'(row_eff);
   assign rsp_valid_in = (s1_go && has_result) ? 1'b1 : stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && has_result) begin
         rsp_bright_ff <= dil;
         rsp_col_ff    <= col_wide[COORD_W-1:0];
         rsp_row_ff    <= row_wide[COORD_W-1:0];
         rsp_last_ff   <= last_col && last_row;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_row_ff, rsp_col_ff, rsp_bright_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
